// File: hdl/mdp_pkg.sv
// mdp_pkg: shared types and constants for the motor demand to PWM unit.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package mdp_pkg;

   localparam int DEMAND_BITS = 16;          // signed demand width
   localparam int DUTY_BITS   = 8;           // duty and register width
   localparam int REM_BITS    = 2 * DUTY_BITS; // product / partial remainder
   localparam int DIV_STEPS   = DUTY_BITS;   // one quotient bit per divider cell
   localparam int CSR_IDX_BITS = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_INVERT_SENSE = 2'd0,
      CSR_DEAD_BAND    = 2'd1,
      CSR_MIN_DUTY     = 2'd2,
      CSR_MAX_PWM      = 2'd3
   } csr_index_type;

   localparam logic [DUTY_BITS-1:0] MAX_PWM_RESET = 8'd255;

   typedef struct packed {
      logic                          cmd;
      logic signed [DEMAND_BITS-1:0] demand;
   } req_type;

   typedef struct packed {
      logic                 direction;
      logic [DUTY_BITS-1:0] duty;
   } rsp_type;

   typedef struct packed {
      logic                 invert_sense;
      logic [DUTY_BITS-1:0] dead_band;
      logic [DUTY_BITS-1:0] min_duty;
      logic [DUTY_BITS-1:0] max_pwm;
   } cfg_type;

   // Per-transaction state handed from cell to cell.
   typedef struct packed {
      logic                 direction;
      logic [DUTY_BITS-1:0] duty;
      logic                 stretch;   // remap applies
      logic                 zero_div;  // max_pwm == 1, remap term is zero
      logic                 neg_term;  // min_duty above max_pwm
      logic [DUTY_BITS-1:0] min_duty;
      logic [DUTY_BITS-1:0] max_pwm;
      logic [DUTY_BITS-1:0] divisor;
      logic [REM_BITS-1:0]  rem;
      logic [DUTY_BITS-1:0] quo;
   } lane_type;

endpackage

`default_nettype wire

// File: hdl/motor_demand_to_pwm_unit.sv
// motor_demand_to_pwm_unit: top level; config registers, cell chain, output skid.
// Depends on mdp_pkg, mdp_shape, mdp_scale, mdp_div_cell.
`default_nettype none

// Maps a signed speed demand onto an H-bridge channel: a direction level
// (1 forward) and an 8-bit PWM duty (0 = held low). The demand is optionally
// negated, clamped to +/- max_pwm and zeroed inside the deadband; a nonzero
// duty is then stretched onto min_duty..max_pwm when min_duty is nonzero,
// using a truncating divide by max_pwm-1. A stop transaction gives direction
// 0 and duty 0. Throughput is one transaction per clock while the skid
// entry is free. A result passes from req acceptance to rsp_valid through
// the chain of cells: shaping (loaded at the accepting edge), multiply,
// eight restoring-divide cells (one quotient bit each) and the output
// register. The whole chain advances together; a two-entry output
// register/skid pair lets req_ready stay a registered signal, so req keeps
// flowing while one result waits on rsp_ready. Configuration writes take
// effect on the next clock and must only happen with the unit idle.
module motor_demand_to_pwm_unit
   import mdp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_type                 req_data,
   // result channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_type                      rsp_data,
   // configuration write port
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [DUTY_BITS-1:0]    csr_wdata
);

   localparam int NCELL = DIV_STEPS + 2;   // shape, scale, divider cells

   cfg_type  cfg_ff;
   logic     adv;
   logic     vld   [NCELL];
   lane_type lane  [NCELL];
   logic     last_vld;
   lane_type last_lane;
   rsp_type  result;
   logic [DUTY_BITS-1:0] term;

   logic     out_vld_ff,  out_vld_in;
   rsp_type  out_ff,      out_in;
   logic     skid_vld_ff, skid_vld_in;
   rsp_type  skid_ff,     skid_in;
   logic     take;

   // ---- configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.invert_sense <= 1'b0;
         cfg_ff.dead_band    <= '0;
         cfg_ff.min_duty     <= '0;
         cfg_ff.max_pwm      <= MAX_PWM_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_INVERT_SENSE: cfg_ff.invert_sense <= csr_wdata[0];
            CSR_DEAD_BAND:    cfg_ff.dead_band    <= csr_wdata;
            CSR_MIN_DUTY:     cfg_ff.min_duty     <= csr_wdata;
            CSR_MAX_PWM:      cfg_ff.max_pwm      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Chain moves only while the skid entry is free: a result leaving the
   // chain always has somewhere to land.
   assign adv       = !skid_vld_ff;
   assign req_ready = !skid_vld_ff;

   // ---- chain of cells ----
   mdp_shape u_shape (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .vld_in  (req_valid),
      .req_in  (req_data),
      .cfg     (cfg_ff),
      .vld_ff  (vld[0]),
      .lane_ff (lane[0])
   );

   mdp_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .vld_in  (vld[0]),
      .lane_in (lane[0]),
      .vld_ff  (vld[1]),
      .lane_ff (lane[1])
   );

   // Quotient bits MSB first; quotient never exceeds DUTY_BITS bits since
   // duty-1 <= max_pwm-1.
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      mdp_div_cell #(
         .BIT (DIV_STEPS - 1 - i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .vld_in  (vld[i+1]),
         .lane_in (lane[i+1]),
         .vld_ff  (vld[i+2]),
         .lane_ff (lane[i+2])
      );
   end

   assign last_vld  = vld[NCELL-1];
   assign last_lane = lane[NCELL-1];

   // Final stretch: min_duty plus signed quotient, truncated to 8 bits.
   always_comb begin
      term = last_lane.neg_term ? (~last_lane.quo + 1'b1) : last_lane.quo;
      result.direction = last_lane.direction;
      if (!last_lane.stretch) begin
         result.duty = last_lane.duty;
      end else if (last_lane.zero_div) begin
         result.duty = last_lane.min_duty;
      end else begin
         result.duty = last_lane.min_duty + term;
      end
   end

   // ---- output register + skid ----
   assign take = out_vld_ff && rsp_ready;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (take) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (last_vld) begin
         if (!out_vld_ff || take) begin
            out_in     = result;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = result;
            skid_vld_in = 1'b1;
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // ---- assertions ----
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry holds a transaction while output register is empty");

   a_frozen_chain: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(last_vld) && $stable(last_lane))
      else $error("chain end changed while the chain was stalled");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (adv && last_vld && out_vld_ff && !rsp_ready) |=> skid_vld_ff)
      else $error("result left the chain with output blocked but skid stayed empty");

endmodule

`default_nettype wire

// File: hdl/mdp_shape.sv
// mdp_shape: first pipeline cell; inversion, clamp, deadband, direction, duty.
// Depends on mdp_pkg.
`default_nettype none

module mdp_shape
   import mdp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     adv,
   input  wire logic     vld_in,
   input  wire req_type  req_in,
   input  wire cfg_type  cfg,
   output logic          vld_ff,
   output lane_type      lane_ff
);

   logic [DEMAND_BITS:0]   dext;
   logic [DEMAND_BITS:0]   mag;
   logic [DEMAND_BITS:0]   lim_ext;
   logic [DUTY_BITS-1:0]   clamped;
   logic [DUTY_BITS-1:0]   duty;
   logic                   neg;
   lane_type               lane_in;

   // Magnitude one bit wider than the demand, so the most negative value
   // needs no saturation: it clamps to max_pwm either way.
   always_comb begin
      dext    = {req_in.demand[DEMAND_BITS-1], req_in.demand};
      mag     = req_in.demand[DEMAND_BITS-1] ? (~dext + 1'b1) : dext;
      lim_ext = {{(DEMAND_BITS+1-DUTY_BITS){1'b0}}, cfg.max_pwm};
      clamped = (mag > lim_ext) ? cfg.max_pwm : mag[DUTY_BITS-1:0];
      duty    = (clamped < cfg.dead_band || req_in.cmd) ? '0 : clamped;
      neg     = req_in.demand[DEMAND_BITS-1] ^ cfg.invert_sense;

      lane_in           = '0;
      lane_in.direction = !req_in.cmd && !(neg && duty != '0);
      lane_in.duty      = duty;
      lane_in.stretch   = (duty != '0) && (cfg.min_duty != '0);
      lane_in.zero_div  = (cfg.max_pwm == DUTY_BITS'(1));
      lane_in.min_duty  = cfg.min_duty;
      lane_in.max_pwm   = cfg.max_pwm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/mdp_scale.sv
// mdp_scale: second pipeline cell; forms (duty-1)*|max_pwm-min_duty| and the divisor.
// Depends on mdp_pkg.
`default_nettype none

module mdp_scale
   import mdp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     adv,
   input  wire logic     vld_in,
   input  wire lane_type lane_in,
   output logic          vld_ff,
   output lane_type      lane_ff
);

   logic [DUTY_BITS-1:0] a;
   logic [DUTY_BITS-1:0] b;
   logic                 neg;
   lane_type             lane_nx;

   always_comb begin
      a   = lane_in.duty - 1'b1;
      neg = lane_in.min_duty > lane_in.max_pwm;
      b   = neg ? (lane_in.min_duty - lane_in.max_pwm)
                : (lane_in.max_pwm - lane_in.min_duty);

      lane_nx          = lane_in;
      lane_nx.neg_term = neg;
      lane_nx.divisor  = lane_in.max_pwm - 1'b1;
      lane_nx.rem      = REM_BITS'(a) * REM_BITS'(b);
      lane_nx.quo      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_nx;
      end
   end

endmodule

`default_nettype wire

// File: hdl/mdp_div_cell.sv
// mdp_div_cell: one restoring-division cell, resolves quotient bit BIT.
// Depends on mdp_pkg.
`default_nettype none

module mdp_div_cell
   import mdp_pkg::*;
#(
   parameter int BIT = 0
)(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     adv,
   input  wire logic     vld_in,
   input  wire lane_type lane_in,
   output logic          vld_ff,
   output lane_type      lane_ff
);

   logic [REM_BITS-1:0] dsh;
   logic                ge;
   lane_type            lane_nx;

   always_comb begin
      dsh          = REM_BITS'(lane_in.divisor) << BIT;
      ge           = lane_in.rem >= dsh;
      lane_nx      = lane_in;
      lane_nx.rem  = ge ? (lane_in.rem - dsh) : lane_in.rem;
      lane_nx.quo[BIT] = ge;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_nx;
      end
   end

endmodule

`default_nettype wire
